// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TLSRD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLSRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`else

`define TLSRD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TLSRD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/tlsrd_pkg.sv -----
// Types, codes and constant byte patterns of the record deframer.
// Used by the parser, the output buffer and the top level.
`default_nettype none

package tlsrd_pkg;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD,
    ST_BIG,
    ST_CLOSED
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       record_end;
    status_t    status;
  } result_t;

  localparam logic [2:0]  CCS_LEN = 3'd6;
  localparam logic [2:0]  HDR_LEN = 3'd5;
  localparam logic [2:0]  HDR_TYPE_LEN = 3'd3;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd16384;

  // Fake ChangeCipherSpec record that may open the stream.
  function automatic logic [7:0] ccs_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h14;
      3'd1:    b = 8'h03;
      3'd2:    b = 8'h03;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Fixed opening of every application data record header.
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h17;
      2'd1:    b = 8'h03;
      2'd2:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tlsrd_parser.sv -----
// Record parser: stream state registers and the per-byte decision logic.
// Depends on tlsrd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlsrd_parser import tlsrd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic [15:0] max_payload,
  output result_t          result
);

  phase_t      phase, phase_next;
  logic [2:0]  byte_index, idx_next;
  logic [7:0]  length_high, len_hi_next;
  logic [15:0] remaining, rem_next;

  logic        use_hdr;
  logic [2:0]  hidx;
  logic [15:0] len_full;

  always_comb begin
    phase_next  = phase;
    idx_next    = byte_index;
    len_hi_next = length_high;
    rem_next    = remaining;
    result      = '0;
    use_hdr     = 1'b0;
    hidx        = '0;
    len_full    = {length_high, in_byte};

    unique case (phase)
      PH_PREFIX: begin
        if (byte_index == 3'd0 && in_byte != ccs_byte(3'd0)) begin
          // No fake record: this byte is the first header byte.
          use_hdr = 1'b1;
        end else if (byte_index >= CCS_LEN || in_byte != ccs_byte(byte_index)) begin
          phase_next    = PH_CLOSED;
          result.status = ST_BAD;
        end else if (byte_index == CCS_LEN - 3'd1) begin
          phase_next = PH_HEADER;
          idx_next   = '0;
        end else begin
          idx_next = byte_index + 3'd1;
        end
      end
      PH_HEADER: begin
        use_hdr = 1'b1;
        hidx    = (byte_index >= HDR_LEN) ? 3'd0 : byte_index;
      end
      PH_PAYLOAD: begin
        if (remaining == 16'd0) begin
          use_hdr = 1'b1;
        end else begin
          rem_next         = remaining - 16'd1;
          result.out_byte  = in_byte;
          result.out_valid = 1'b1;
          if (remaining == 16'd1) begin
            result.record_end = 1'b1;
            phase_next        = PH_HEADER;
            idx_next          = '0;
          end
        end
      end
      PH_CLOSED: begin
        result.status = ST_CLOSED;
      end
    endcase

    if (use_hdr) begin
      if (hidx < HDR_TYPE_LEN) begin
        if (in_byte != hdr_byte(hidx[1:0])) begin
          phase_next    = PH_CLOSED;
          result.status = ST_BAD;
        end else begin
          phase_next = PH_HEADER;
          idx_next   = hidx + 3'd1;
        end
      end else if (hidx == HDR_TYPE_LEN) begin
        phase_next  = PH_HEADER;
        len_hi_next = in_byte;
        idx_next    = hidx + 3'd1;
      end else begin
        idx_next = '0;
        if (len_full > max_payload) begin
          phase_next    = PH_CLOSED;
          result.status = ST_BIG;
        end else if (len_full == 16'd0) begin
          // Empty record ends on its last length byte.
          phase_next        = PH_HEADER;
          result.record_end = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
          rem_next   = len_full;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PREFIX;
      byte_index  <= '0;
      length_high <= '0;
      remaining   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_index  <= idx_next;
      length_high <= len_hi_next;
      remaining   <= rem_next;
    end
  end

  `TLSRD_ASSERT_NEXT(a_closed_sticks, clk, rst, phase == PH_CLOSED, phase == PH_CLOSED)
  `TLSRD_ASSERT_IMPL(a_prefix_idx, clk, rst, phase == PH_PREFIX, byte_index < CCS_LEN)
  `TLSRD_ASSERT_IMPL(a_header_idx, clk, rst, phase == PH_HEADER, byte_index < HDR_LEN)
  `TLSRD_ASSERT_IMPL(a_payload_due, clk, rst, phase == PH_PAYLOAD, remaining != 16'd0)

endmodule

`default_nettype wire

// ----- rtl/tlsrd_outbuf.sv -----
// Two-entry result buffer: an output register plus a skid register.
// Depends on tlsrd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlsrd_outbuf import tlsrd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  result_t   push_data,
  output logic      full,
  output logic      main_valid,
  output result_t   main_data,
  input  wire logic take_stall
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = main_valid && !take_stall;
  // Stall upstream only once the skid entry is occupied.
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  `TLSRD_ASSERT_IMPL(a_skid_behind_main, clk, rst, skid_valid, main_valid)
  `TLSRD_ASSERT_NEXT(a_skid_fills, clk, rst, push && main_valid && !pop, skid_valid)
  `TLSRD_ASSERT_IMPL(a_no_push_full, clk, rst, skid_valid, !push)

endmodule

`default_nettype wire

// ----- rtl/tls_record_deframer_unit.sv -----
// Top level of the TLS record deframer: limit register, parser, output buffer.
// Depends on tlsrd_pkg, tlsrd_parser and tlsrd_outbuf.
// The result of a byte is registered in the output buffer before it is presented.
// Throughput: one byte per cycle while the output buffer is not full; the parser state is registered.
// A two-entry output buffer lets one more byte in while a result is stalled.
// Synchronous reset returns to the prefix check and sets the limit to 16384.
`default_nettype none

module tls_record_deframer_unit import tlsrd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             record_end,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] max_payload;
  logic        accept;
  logic        buf_full;
  result_t     step_result;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  tlsrd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .max_payload (max_payload),
    .result      (step_result)
  );

  tlsrd_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (step_result),
    .full       (buf_full),
    .main_valid (result_valid),
    .main_data  (head),
    .take_stall (result_stall)
  );

  assign out_byte   = head.out_byte;
  assign out_valid  = head.out_valid;
  assign record_end = head.record_end;
  assign status     = head.status;

endmodule

`default_nettype wire

// ----- tb/tls_record_deframer_unit_tb.sv -----
// Self-checking testbench of the TLS record deframer: random records with stalls on both sides.
// Needs tlsrd_pkg and the tls_record_deframer_unit RTL; a predictor class tracks results.
import tlsrd_pkg::*;

class deframe_predictor;
  localparam logic [47:0] FAKE_CCS = 48'h14_03_03_00_01_01;
  localparam logic [23:0] APP_OPEN = 24'h17_03_03;

  phase_t      phase;
  logic [2:0]  pos;
  logic [7:0]  len_hi;
  logic [15:0] remaining;
  logic [15:0] limit;
  result_t     due_results[$];
  int          mismatches;
  int          bytes_taken;
  int          records_done;
  int          payload_bytes;
  status_t     close_cause;

  function new();
    phase         = PH_PREFIX;
    pos           = '0;
    len_hi        = '0;
    remaining     = '0;
    limit         = MAX_PAYLOAD_RESET;
    mismatches    = 0;
    bytes_taken   = 0;
    records_done  = 0;
    payload_bytes = 0;
    close_cause   = ST_OK;
  endfunction

  function void set_limit(logic [15:0] v);
    limit = v;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  function void header_step(input logic [7:0] b, inout result_t r);
    logic [15:0] len;
    if (pos < HDR_TYPE_LEN) begin
      if (b != APP_OPEN[8*(2-int'(pos)) +: 8]) begin
        phase = PH_CLOSED;
        r.status = ST_BAD;
      end else begin
        pos++;
      end
    end else if (pos == 3'd3) begin
      len_hi = b;
      pos = 3'd4;
    end else begin
      len = {len_hi, b};
      pos = '0;
      if (len > limit) begin
        phase = PH_CLOSED;
        r.status = ST_BIG;
      end else if (len == 16'd0) begin
        r.record_end = 1'b1;
        phase = PH_HEADER;
      end else begin
        remaining = len;
        phase = PH_PAYLOAD;
      end
    end
  endfunction

  // Works out the result of one accepted byte and queues it.
  function void accept_byte(logic [7:0] b);
    result_t r;
    r = '0;
    bytes_taken++;
    case (phase)
      PH_PREFIX: begin
        if (pos == 3'd0 && b != FAKE_CCS[47:40]) begin
          phase = PH_HEADER;
          header_step(b, r);
        end else if (pos >= CCS_LEN || b != FAKE_CCS[8*(5-int'(pos)) +: 8]) begin
          // A broken fake record fails like a header that does not begin 17.
          phase = PH_CLOSED;
          r.status = ST_BAD;
        end else begin
          pos++;
          if (pos == CCS_LEN) begin
            phase = PH_HEADER;
            pos = '0;
          end
        end
      end
      PH_HEADER: begin
        if (pos >= HDR_LEN) pos = '0;
        header_step(b, r);
      end
      PH_PAYLOAD: begin
        if (remaining == 16'd0) begin
          phase = PH_HEADER;
          pos = '0;
          header_step(b, r);
        end else begin
          remaining--;
          r.out_byte  = b;
          r.out_valid = 1'b1;
          if (remaining == 16'd0) begin
            r.record_end = 1'b1;
            phase = PH_HEADER;
            pos = '0;
          end
        end
      end
      default: r.status = ST_CLOSED;
    endcase
    if (r.record_end) records_done++;
    if (r.out_valid) payload_bytes++;
    if (r.status == ST_BAD || r.status == ST_BIG) close_cause = r.status;
    due_results.push_back(r);
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  task check_output(logic [7:0] ob, logic ov, logic re, logic [1:0] st);
    result_t w;
    if (due_results.size() == 0) begin
      report_mismatch("result with no request waiting", int'({ob, ov, re, st}), 0);
    end else begin
      w = due_results.pop_front();
      if (ob !== w.out_byte) report_mismatch("out_byte", int'(ob), int'(w.out_byte));
      if (ov !== w.out_valid) report_mismatch("out_valid", int'(ov), int'(w.out_valid));
      if (re !== w.record_end) report_mismatch("record_end", int'(re), int'(w.record_end));
      if (st !== w.status) report_mismatch("status", int'(st), int'(w.status));
    end
  endtask
endclass

module tls_record_deframer_unit_tb;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        result_valid;
  logic        result_stall;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        record_end;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  int          settings = 0;
  deframe_predictor sb;

  tls_record_deframer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .record_end   (record_end),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_output(out_byte, out_valid, record_end, status);
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_side
    int n;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.accept_byte(b);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom_range(0, 255));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_header(logic [15:0] len);
    send_byte(8'h17);
    send_byte(8'h03);
    send_byte(8'h03);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_record(int len);
    send_header(16'(len));
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic run_records(int budget, int cap);
    int start;
    int hi;
    start = sb.bytes_taken;
    hi = (int'(sb.limit) < cap) ? int'(sb.limit) : cap;
    while (sb.bytes_taken - start < budget)
      send_record(($urandom_range(0, 5) == 0) ? hi : $urandom_range(0, hi));
  endtask

  // The sender holds back until every expected result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(v);
    settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int    start_kind;
    int    cause;
    int    k;
    logic [7:0] good;
    string opening;
    sb = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    cfg_valid = 1'b0;
    cfg_data  = 16'h0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Stream opening: the fake record or none about equally often, rarely a broken one.
    start_kind = $urandom_range(0, 15);
    if (start_kind == 0) begin
      opening = "broken fake record";
      k = $urandom_range(1, 5);
      for (int i = 0; i < k; i++) send_byte(ccs_byte(3'(i)));
      send_byte(ccs_byte(3'(k)) ^ 8'($urandom_range(1, 255)));
    end else if (start_kind < 8) begin
      opening = "no fake record";
    end else begin
      opening = "fake record dropped";
      for (int i = 0; i < 6; i++) send_byte(ccs_byte(3'(i)));
    end
    send_record(0);
    send_header(16'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_record(1);

    write_limit(16'd0);
    run_records(60, 8);

    write_limit(16'hFFFF);
    hold_req = 1'b1;
    run_records(150, 20);

    write_limit(16'd1);
    run_records(120, 1);

    // A long record puts a nonzero high length byte on the wire.
    write_limit(16'd300);
    send_record($urandom_range(256, 300));
    run_records(80, 20);

    write_limit(16'($urandom_range(2, 64)));
    run_records(200, 24);

    write_limit(16'($urandom_range(0, 40)));
    quiet = 1'b1;
    run_records(200, 16);

    // Close the stream with a bad header byte or an oversized length.
    cause = $urandom_range(0, 3);
    if (cause < 3) begin
      for (int i = 0; i < cause; i++) send_byte(hdr_byte(2'(i)));
      good = hdr_byte(2'(cause));
      send_byte(good ^ 8'($urandom_range(1, 255)));
    end else begin
      send_header(sb.limit + 16'd1);
    end
    repeat (8) send_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (8) @(posedge clk);

    $display("%0d bytes in, %0d records ended, %0d payload bytes, %0d limit settings",
             sb.bytes_taken, sb.records_done, sb.payload_bytes, settings);
    $display("opening: %s; stream closed by %s", opening, sb.close_cause.name());
    if (sb.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
